/* src/sau_pkg.sv */
// shared types, codes and sizes for the stack alu unit
package sau_pkg;

    localparam int STACK_DEPTH = 64;
    localparam int PTR_W       = $clog2(STACK_DEPTH);
    localparam int CNT_W       = $clog2(STACK_DEPTH + 1);
    localparam int DATA_W      = 32;
    localparam int ACT_W       = 3;
    localparam int DEPTH_W     = 7;
    localparam int STATUS_W    = 2;
    localparam int DIV_STEPS   = DATA_W;
    localparam int STEP_W      = $clog2(DIV_STEPS);

    localparam logic [ACT_W-1:0] ACT_PUSH = 3'd0;
    localparam logic [ACT_W-1:0] ACT_ADD  = 3'd1;
    localparam logic [ACT_W-1:0] ACT_SUB  = 3'd2;
    localparam logic [ACT_W-1:0] ACT_DIV  = 3'd3;
    localparam logic [ACT_W-1:0] ACT_MUL  = 3'd4;
    localparam logic [ACT_W-1:0] ACT_MOD  = 3'd5;

    localparam logic [STATUS_W-1:0] STAT_OK      = 2'd0;
    localparam logic [STATUS_W-1:0] STAT_SHORT   = 2'd1;
    localparam logic [STATUS_W-1:0] STAT_DIVZERO = 2'd2;
    localparam logic [STATUS_W-1:0] STAT_FULL    = 2'd3;

    typedef struct packed {
        logic [ACT_W-1:0]         action;
        logic signed [DATA_W-1:0] push_value;
    } sau_in_t;

    typedef struct packed {
        logic signed [DATA_W-1:0] top_value;
        logic [DEPTH_W-1:0]       stack_depth;
        logic [STATUS_W-1:0]      status;
    } sau_out_t;

    typedef struct packed {
        logic              start;
        logic [ACT_W-1:0]  action;
        logic [DATA_W-1:0] a;
        logic [DATA_W-1:0] b;
    } sau_alu_req_t;

    typedef struct packed {
        logic              done;
        logic [DATA_W-1:0] result;
    } sau_alu_rsp_t;

endpackage

/* src/sau_stack_mem.sv */
// operand stack storage below the top entry, one write and one registered read port
module sau_stack_mem (
    input  logic                        aclk,
    input  logic                        wr_en,
    input  logic [sau_pkg::PTR_W-1:0]   wr_addr,
    input  logic [sau_pkg::DATA_W-1:0]  wr_data,
    input  logic                        rd_en,
    input  logic [sau_pkg::PTR_W-1:0]   rd_addr,
    output logic [sau_pkg::DATA_W-1:0]  rd_data
);
    import sau_pkg::*;

    logic [DATA_W-1:0] mem [STACK_DEPTH];
    logic [DATA_W-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

/* src/sau_alu.sv */
// shared arithmetic unit: add, sub and mul computed directly, div and mod by radix-2 iteration
module sau_alu (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  sau_pkg::sau_alu_req_t  req,
    output sau_pkg::sau_alu_rsp_t  rsp
);
    import sau_pkg::*;

    localparam logic [1:0] A_IDLE = 2'd0;
    localparam logic [1:0] A_DIV  = 2'd1;
    localparam logic [1:0] A_FIX  = 2'd2;

    logic [1:0]        state_reg, state_next;
    logic              done_reg, done_next;
    logic [DATA_W-1:0] res_reg, res_next;
    logic [DATA_W-1:0] rem_reg, rem_next;
    logic [DATA_W-1:0] quo_reg, quo_next;
    logic [DATA_W-1:0] dvs_reg, dvs_next;
    logic [STEP_W-1:0] step_reg, step_next;
    logic              neg_q_reg, neg_q_next;
    logic              neg_r_reg, neg_r_next;
    logic              is_mod_reg, is_mod_next;

    logic [DATA_W-1:0] abs_a, abs_b;
    logic [DATA_W:0]   rem_sh, diff;

    assign abs_a  = req.a[DATA_W-1] ? (~req.a + DATA_W'(1)) : req.a;
    assign abs_b  = req.b[DATA_W-1] ? (~req.b + DATA_W'(1)) : req.b;
    // shift one dividend bit in, trial subtract
    assign rem_sh = {rem_reg, quo_reg[DATA_W-1]};
    assign diff   = rem_sh - {1'b0, dvs_reg};

    always_comb begin
        state_next  = state_reg;
        done_next   = 1'b0;
        res_next    = res_reg;
        rem_next    = rem_reg;
        quo_next    = quo_reg;
        dvs_next    = dvs_reg;
        step_next   = step_reg;
        neg_q_next  = neg_q_reg;
        neg_r_next  = neg_r_reg;
        is_mod_next = is_mod_reg;
        case (state_reg)
            A_IDLE: begin
                if (req.start) begin
                    case (req.action)
                        ACT_ADD: begin
                            res_next  = req.a + req.b;
                            done_next = 1'b1;
                        end
                        ACT_SUB: begin
                            res_next  = req.a - req.b;
                            done_next = 1'b1;
                        end
                        ACT_MUL: begin
                            res_next  = DATA_W'(req.a * req.b);
                            done_next = 1'b1;
                        end
                        ACT_DIV, ACT_MOD: begin
                            rem_next    = '0;
                            quo_next    = abs_a;
                            dvs_next    = abs_b;
                            step_next   = '0;
                            neg_q_next  = req.a[DATA_W-1] ^ req.b[DATA_W-1];
                            neg_r_next  = req.a[DATA_W-1];
                            is_mod_next = (req.action == ACT_MOD);
                            state_next  = A_DIV;
                        end
                        default: begin
                            res_next  = req.a;
                            done_next = 1'b1;
                        end
                    endcase
                end
            end
            A_DIV: begin
                if (!diff[DATA_W]) begin
                    rem_next = diff[DATA_W-1:0];
                    quo_next = {quo_reg[DATA_W-2:0], 1'b1};
                end else begin
                    rem_next = rem_sh[DATA_W-1:0];
                    quo_next = {quo_reg[DATA_W-2:0], 1'b0};
                end
                step_next = step_reg + STEP_W'(1);
                if (step_reg == STEP_W'(DIV_STEPS - 1)) begin
                    state_next = A_FIX;
                end
            end
            A_FIX: begin
                // quotient sign from both operands, remainder sign from the dividend
                if (is_mod_reg) begin
                    res_next = neg_r_reg ? (~rem_reg + DATA_W'(1)) : rem_reg;
                end else begin
                    res_next = neg_q_reg ? (~quo_reg + DATA_W'(1)) : quo_reg;
                end
                done_next  = 1'b1;
                state_next = A_IDLE;
            end
            default: begin
                state_next = A_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= A_IDLE;
            done_reg  <= 1'b0;
        end else begin
            state_reg <= state_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge aclk) begin
        res_reg    <= res_next;
        rem_reg    <= rem_next;
        quo_reg    <= quo_next;
        dvs_reg    <= dvs_next;
        step_reg   <= step_next;
        neg_q_reg  <= neg_q_next;
        neg_r_reg  <= neg_r_next;
        is_mod_reg <= is_mod_next;
    end

    assign rsp.done   = done_reg;
    assign rsp.result = res_reg;

    a_no_start_while_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg != A_IDLE |-> !req.start)
        else $error("alu started while dividing");

    a_fix_gives_done: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == A_FIX |=> done_reg)
        else $error("divide finish did not signal done");

    a_done_one_cycle: assert property (@(posedge aclk) disable iff (!aresetn)
        done_reg |=> !done_reg)
        else $error("done held longer than one cycle");

endmodule

/* src/stack_alu_int_unit.sv */
// top level: operand stack sequencer with shared arithmetic unit
//
//  channel | dir | handshake          | payload
//  s_      | in  | s_valid / s_ready  | s_data : action, push_value
//  m_      | out | m_valid / m_ready  | m_data : top_value, stack_depth, status
//
// push, too short, full and unused codes go from accept straight to the result state
// a zero divisor goes through stack read, then result
// add, sub and mul go through stack read, alu operation, handoff, result
// div and mod run through the 32 steps of the radix-2 divider
// one item at a time; s_ready is low until the previous result is registered
// a stalled result holds in the output register; reset empties the stack
module stack_alu_int_unit (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  sau_pkg::sau_in_t  s_data,
    output logic              m_valid,
    input  logic              m_ready,
    output sau_pkg::sau_out_t m_data
);
    import sau_pkg::*;

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_OPER = 2'd1;
    localparam logic [1:0] S_CALC = 2'd2;
    localparam logic [1:0] S_RESP = 2'd3;

    logic [1:0]          state_reg, state_next;
    logic [CNT_W-1:0]    count_reg, count_next;
    logic [DATA_W-1:0]   top_reg, top_next;
    logic [ACT_W-1:0]    act_reg, act_next;
    logic [STATUS_W-1:0] status_reg, status_next;
    logic                m_valid_reg, m_valid_next;
    sau_out_t            m_data_reg, m_data_next;

    logic                accept;
    logic                wr_en, rd_en;
    logic [PTR_W-1:0]    wr_addr, rd_addr;
    logic [DATA_W-1:0]   rd_data;
    sau_alu_req_t        alu_req;
    sau_alu_rsp_t        alu_rsp;
    logic                is_arith, is_divmod;

    assign s_ready  = (state_reg == S_IDLE);
    assign accept   = s_valid && s_ready;
    assign is_arith = (s_data.action inside {[ACT_ADD:ACT_MOD]});
    assign is_divmod = (act_reg == ACT_DIV) || (act_reg == ACT_MOD);

    // the top entry lives in top_reg; memory holds the entries beneath it
    assign wr_en   = accept && (s_data.action == ACT_PUSH) && (count_reg != '0)
                     && (count_reg != CNT_W'(STACK_DEPTH));
    assign wr_addr = PTR_W'(count_reg - CNT_W'(1));
    assign rd_en   = accept && is_arith && (count_reg >= CNT_W'(2));
    assign rd_addr = PTR_W'(count_reg - CNT_W'(2));

    sau_stack_mem u_mem (
        .aclk    (aclk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (top_reg),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    assign alu_req.start  = (state_reg == S_OPER) && !(is_divmod && (top_reg == '0));
    assign alu_req.action = act_reg;
    assign alu_req.a      = rd_data;
    assign alu_req.b      = top_reg;

    sau_alu u_alu (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (alu_req),
        .rsp     (alu_rsp)
    );

    always_comb begin
        state_next   = state_reg;
        count_next   = count_reg;
        top_next     = top_reg;
        act_next     = act_reg;
        status_next  = status_reg;
        m_valid_next = m_valid_reg;
        m_data_next  = m_data_reg;
        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end
        case (state_reg)
            S_IDLE: begin
                if (accept) begin
                    act_next    = s_data.action;
                    status_next = STAT_OK;
                    state_next  = S_RESP;
                    if (s_data.action == ACT_PUSH) begin
                        if (count_reg == CNT_W'(STACK_DEPTH)) begin
                            status_next = STAT_FULL;
                        end else begin
                            top_next   = s_data.push_value;
                            count_next = count_reg + CNT_W'(1);
                        end
                    end else if (is_arith) begin
                        if (count_reg < CNT_W'(2)) begin
                            status_next = STAT_SHORT;
                        end else begin
                            state_next = S_OPER;
                        end
                    end
                end
            end
            S_OPER: begin
                if (is_divmod && (top_reg == '0)) begin
                    status_next = STAT_DIVZERO;
                    state_next  = S_RESP;
                end else begin
                    state_next = S_CALC;
                end
            end
            S_CALC: begin
                if (alu_rsp.done) begin
                    top_next   = alu_rsp.result;
                    count_next = count_reg - CNT_W'(1);
                    state_next = S_RESP;
                end
            end
            S_RESP: begin
                if (!m_valid_reg || m_ready) begin
                    m_valid_next            = 1'b1;
                    m_data_next.top_value   = (count_reg != '0) ? top_reg : '0;
                    m_data_next.stack_depth = DEPTH_W'(count_reg);
                    m_data_next.status      = status_reg;
                    state_next              = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            count_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            count_reg   <= count_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        top_reg    <= top_next;
        act_reg    <= act_next;
        status_reg <= status_next;
        m_data_reg <= m_data_next;
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CNT_W'(STACK_DEPTH))
        else $error("stack count beyond capacity");

    a_alu_done_in_calc: assert property (@(posedge aclk) disable iff (!aresetn)
        alu_rsp.done |-> state_reg == S_CALC)
        else $error("alu result outside calc state");

    a_result_from_resp: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid_reg) |-> $past(state_reg) == S_RESP)
        else $error("result raised outside resp state");

    a_count_step: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == S_CALC && alu_rsp.done |=> count_reg == $past(count_reg) - CNT_W'(1))
        else $error("arithmetic did not drop one entry");

endmodule

/* tb/tb_stack_alu_int_unit.sv */
// testbench for stack_alu_int_unit: queued stimulus, predicting monitor
`timescale 1ns / 100ps

module tb_stack_alu_int_unit;
    import sau_pkg::*;

    localparam logic [ACT_W-1:0] ACT_SPARE_6 = 3'd6;
    localparam logic [ACT_W-1:0] ACT_SPARE_7 = 3'd7;
    localparam logic [DATA_W-1:0] INT_MIN = 32'h8000_0000;
    localparam logic [DATA_W-1:0] INT_MAX = 32'h7fff_ffff;
    localparam int RANDOM_OPS = 850;
    localparam int DRAIN_CYCLES = 40;

    logic     aclk;
    logic     aresetn = 1'b0;
    logic     s_valid = 1'b0;
    logic     s_ready;
    sau_in_t  s_data = '0;
    logic     m_valid;
    logic     m_ready = 1'b0;
    sau_out_t m_data;

    stack_alu_int_unit u_dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    sau_in_t  op_backlog[$];
    sau_out_t results_due[$];
    sau_out_t oldest_due;

    // shadow of the operand stack, updated as items are accepted
    logic [DATA_W-1:0] mirror_stack [STACK_DEPTH];
    int mirror_count = 0;

    int est_depth = 0;
    int total_items = 0;
    int items_accepted = 0;
    int results_checked = 0;
    int mismatches = 0;
    int max_depth_seen = 0;
    int status_seen [4] = '{0, 0, 0, 0};
    int send_idle_pct = 33;
    int recv_idle_pct = 70;

    initial begin
        aclk = 1'b0;
        forever #6 aclk = ~aclk;
    end

    function automatic sau_out_t apply_stack_op(sau_in_t op);
        sau_out_t r;
        logic [DATA_W-1:0] lhs, rhs, res;
        longint sa, sb, q;
        r = '0;
        r.status = STAT_OK;
        if (op.action == ACT_PUSH) begin
            if (mirror_count >= STACK_DEPTH) begin
                r.status = STAT_FULL;
            end else begin
                mirror_stack[mirror_count] = op.push_value;
                mirror_count++;
            end
        end else if (op.action <= ACT_MOD) begin
            if (mirror_count < 2) begin
                r.status = STAT_SHORT;
            end else begin
                rhs = mirror_stack[mirror_count-1];
                lhs = mirror_stack[mirror_count-2];
                if ((op.action == ACT_DIV || op.action == ACT_MOD) && rhs == '0) begin
                    r.status = STAT_DIVZERO;
                end else begin
                    // 64-bit signed math keeps INT_MIN / -1 well defined
                    sa = signed'(lhs);
                    sb = signed'(rhs);
                    case (op.action)
                        ACT_ADD: res = lhs + rhs;
                        ACT_SUB: res = lhs - rhs;
                        ACT_MUL: res = lhs * rhs;
                        ACT_DIV: begin
                            q = sa / sb;
                            res = q[DATA_W-1:0];
                        end
                        default: begin
                            q = sa % sb;
                            res = q[DATA_W-1:0];
                        end
                    endcase
                    mirror_stack[mirror_count-2] = res;
                    mirror_count--;
                end
            end
        end
        if (mirror_count > 0)
            r.top_value = mirror_stack[mirror_count-1];
        r.stack_depth = DEPTH_W'(mirror_count);
        return r;
    endfunction

    task automatic flag_mismatch(input string what);
        mismatches++;
        $display("%0t ns: result %0d: %s", $time, results_checked, what);
    endtask

    // depth estimate only shapes the stimulus, a zero divisor can skew it
    task automatic queue_op(input logic [ACT_W-1:0] act, input logic [DATA_W-1:0] val);
        sau_in_t it;
        it.action = act;
        it.push_value = val;
        op_backlog.push_back(it);
        if (act == ACT_PUSH) begin
            if (est_depth < STACK_DEPTH)
                est_depth++;
        end else if (act <= ACT_MOD) begin
            if (est_depth >= 2)
                est_depth--;
        end
    endtask

    function automatic logic [DATA_W-1:0] pick_value();
        case ($urandom_range(0, 9))
            0: return INT_MIN;
            1: return INT_MAX;
            2: return '0;
            3: return '1;
            4, 5: return DATA_W'($urandom_range(0, 40)) - 32'd20;
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [ACT_W-1:0] pick_arith();
        return ACT_W'($urandom_range(ACT_ADD, ACT_MOD));
    endfunction

    task automatic build_stimulus();
        int kind, len, floor_depth;
        bit filled;
        filled = 0;
        // empty and one-deep stack, wraparound, overflowing quotient, zero divisor
        queue_op(ACT_ADD, $urandom);
        queue_op(ACT_SPARE_6, $urandom);
        queue_op(ACT_PUSH, INT_MAX);
        queue_op(ACT_MOD, $urandom);
        queue_op(ACT_PUSH, 32'd1);
        queue_op(ACT_ADD, '0);
        queue_op(ACT_PUSH, '1);
        queue_op(ACT_DIV, '1);
        queue_op(ACT_PUSH, '1);
        queue_op(ACT_MOD, '0);
        queue_op(ACT_PUSH, '0);
        queue_op(ACT_DIV, INT_MIN);
        queue_op(ACT_MOD, INT_MAX);
        queue_op(ACT_SPARE_7, '1);
        queue_op(ACT_SUB, $urandom);
        queue_op(ACT_PUSH, -32'sd7);
        queue_op(ACT_PUSH, 32'd2);
        queue_op(ACT_DIV, '0);
        queue_op(ACT_PUSH, 32'd2);
        queue_op(ACT_MOD, '0);
        queue_op(ACT_PUSH, INT_MIN);
        queue_op(ACT_MUL, '0);
        queue_op(ACT_PUSH, INT_MAX);
        queue_op(ACT_SUB, '0);
        queue_op(ACT_ADD, '0);

        while (op_backlog.size() < RANDOM_OPS) begin
            kind = $urandom_range(0, 99);
            if (!filled && op_backlog.size() > 300)
                kind = 75;
            if (kind < 70) begin
                // well-formed expression with random operands
                len = $urandom_range(6, 20);
                repeat (len) begin
                    if (est_depth < 2)
                        queue_op(ACT_PUSH, pick_value());
                    else if (est_depth >= STACK_DEPTH - 4 || $urandom_range(0, 1))
                        queue_op(pick_arith(), $urandom);
                    else
                        queue_op(ACT_PUSH, pick_value());
                end
            end else if (kind < 80) begin
                // fill to capacity, push past it, then drain to near empty
                filled = 1;
                while (est_depth < STACK_DEPTH)
                    queue_op(ACT_PUSH, pick_value());
                repeat ($urandom_range(1, 3))
                    queue_op(ACT_PUSH, pick_value());
                floor_depth = $urandom_range(1, 2);
                while (est_depth > floor_depth)
                    queue_op(pick_arith(), $urandom);
                queue_op(pick_arith(), $urandom);
            end else begin
                repeat ($urandom_range(3, 8))
                    queue_op(ACT_W'($urandom_range(0, 7)), $urandom);
            end
        end
    endtask

    // driver: presents items from the backlog, predicts on each accept
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
            s_data  <= '0;
        end else begin
            if (s_valid && s_ready) begin
                results_due.push_back(apply_stack_op(s_data));
                items_accepted++;
                if (mirror_count > max_depth_seen)
                    max_depth_seen = mirror_count;
            end
            if (!s_valid || s_ready) begin
                if (op_backlog.size() > 0 && $urandom_range(0, 99) >= send_idle_pct) begin
                    s_valid <= 1'b1;
                    s_data  <= op_backlog.pop_front();
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // monitor: checks each result against the oldest prediction
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            if (m_valid && m_ready) begin
                if (results_due.size() == 0) begin
                    flag_mismatch("result arrived with nothing expected");
                end else begin
                    oldest_due = results_due.pop_front();
                    if (m_data.top_value !== oldest_due.top_value)
                        flag_mismatch($sformatf("top_value got %0d expected %0d",
                            m_data.top_value, oldest_due.top_value));
                    if (m_data.stack_depth !== oldest_due.stack_depth)
                        flag_mismatch($sformatf("stack_depth got %0d expected %0d",
                            m_data.stack_depth, oldest_due.stack_depth));
                    if (m_data.status !== oldest_due.status)
                        flag_mismatch($sformatf("status got %0d expected %0d",
                            m_data.status, oldest_due.status));
                    status_seen[oldest_due.status]++;
                    results_checked++;
                end
            end
            m_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
        end
    end

    initial begin
        build_stimulus();
        total_items = op_backlog.size();
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;

        wait (items_accepted >= total_items / 3);
        send_idle_pct = 70;
        recv_idle_pct = 33;
        wait (items_accepted >= 2 * total_items / 3);
        send_idle_pct = 0;
        recv_idle_pct = 0;
        wait (items_accepted >= total_items);
        wait (results_due.size() == 0);
        repeat (DRAIN_CYCLES) @(posedge aclk);

        $display("checked %0d results: %0d ok, %0d too short, %0d divide by zero, %0d full",
            results_checked, status_seen[STAT_OK], status_seen[STAT_SHORT],
            status_seen[STAT_DIVZERO], status_seen[STAT_FULL]);
        $display("deepest stack %0d, %0d mismatches", max_depth_seen, mismatches);
        if (mismatches == 0 && results_due.size() == 0) begin
            $display("stack_alu_int_unit test passed");
        end else begin
            $display("stack_alu_int_unit test failed");
        end
        $finish;
    end

    // watchdog, far beyond the slowest legal run
    initial begin
        #(10_000_000);
        $display("stack_alu_int_unit test failed");
        $finish;
    end

endmodule

/* stack_alu_int_unit.f */
src/sau_pkg.sv
src/sau_stack_mem.sv
src/sau_alu.sv
src/stack_alu_int_unit.sv
tb/tb_stack_alu_int_unit.sv
